>>> rtl/leaf_vector_running_mean_macros.svh
// assertion macros shared by the checker of leaf_vector_running_mean
// no dependencies; taken in by `include
`ifndef LEAF_VECTOR_RUNNING_MEAN_MACROS_SVH
`define LEAF_VECTOR_RUNNING_MEAN_MACROS_SVH

// same-cycle implication under reset
`define LVRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lvrm check failed");

// next-cycle implication under reset
`define LVRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lvrm check failed");

`endif

>>> rtl/lvrm_pkg.sv
// shared types and constants for the leaf vector running mean block
// no dependencies
package lvrm_pkg;

	localparam int LEAF_DIM_DEF = 8;
	localparam int MODE_W = 2;
	localparam int COMP_W = 3;
	localparam int VAL_W  = 32;
	localparam int WT_W   = 16;
	localparam int SUM_W  = 64;
	localparam int PROD_W = VAL_W + WT_W + 1;

	localparam logic [WT_W-1:0]  CNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_MERGE = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_PREP,
		ST_DIV,
		ST_MEAN,
		ST_RES
	} st_t;

endpackage

>>> rtl/lvrm_if.sv
// request and result channel interfaces for the leaf vector running mean block
// depends on lvrm_pkg
interface lvrm_in_if;
	import lvrm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [COMP_W-1:0]        component;
	logic signed [VAL_W-1:0]  value;
	logic [WT_W-1:0]          weight;
	logic                     end_of_vector;

	modport source (output valid, mode, component, value, weight, end_of_vector,
		input ready);
	modport sink (input valid, mode, component, value, weight, end_of_vector,
		output ready);
endinterface

interface lvrm_out_if;
	import lvrm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  mean_value;
	logic signed [VAL_W-1:0]  residual;
	logic [WT_W-1:0]          sample_count;
	logic                     saturated;
	logic                     empty_res;

	modport source (output valid, mean_value, residual, sample_count, saturated,
		empty_res, input ready);
	modport sink (input valid, mean_value, residual, sample_count, saturated,
		empty_res, output ready);
endinterface

>>> rtl/leaf_vector_running_mean.sv
// leaf_vector_running_mean: per-component 64-bit sums and one shared sample count.
// the mean comes from the radix-2 divider, which is skipped when the count is 0; one request
// at a time, the next accepted while a result waits, and held in its last state while that
// result is unread.
// reset: sums read as zero through per-entry valid bits, count zero, channels idle.
// depends on lvrm_pkg, lvrm_if and lvrm_div
module leaf_vector_running_mean #(
	parameter int LEAF_DIM = lvrm_pkg::LEAF_DIM_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	lvrm_in_if.sink  item,
	lvrm_out_if.source result
);
	import lvrm_pkg::*;

	localparam int IW = (LEAF_DIM > 1) ? $clog2(LEAF_DIM) : 1;

	st_t state_q, state_d;

	// latched request
	mode_t                   mode_q;
	logic [IW-1:0]           idx_q;
	logic                    ok_q;
	logic signed [VAL_W-1:0] val_q;
	logic [WT_W-1:0]         wt_q;
	logic                    eov_q;

	// sum store
	logic [SUM_W-1:0]      sum_mem [LEAF_DIM];
	logic [LEAF_DIM-1:0]   vld_q;
	logic [SUM_W-1:0]      rd_q;
	logic                  rvld_q;

	// datapath registers
	logic [SUM_W-1:0]        addend_q;
	logic [SUM_W-1:0]        sum_q;
	logic [WT_W-1:0]         cnt_q;
	logic                    sat_q;
	logic                    neg_q;
	logic signed [VAL_W-1:0] mean_q;

	// result register
	logic                    ovalid_q;
	logic signed [VAL_W-1:0] o_mean_q;
	logic signed [VAL_W-1:0] o_res_q;
	logic [WT_W-1:0]         o_cnt_q;
	logic                    o_sat_q;
	logic                    o_empty_q;

	logic                    accept;
	logic                    take;
	logic                    div_start;
	logic                    out_load;
	logic                    div_done;
	logic [SUM_W-1:0]        quot;
	logic signed [PROD_W-1:0] prod;
	logic [SUM_W-1:0]        cur;
	logic [SUM_W-1:0]        add_raw;
	logic                    add_ovf;
	logic [SUM_W-1:0]        add_sat;
	logic [WT_W:0]           cnt_sum;
	logic [SUM_W-1:0]        mag;
	logic                    mean_big;
	logic [VAL_W-1:0]        mean_d;
	logic [VAL_W:0]          diff;
	logic                    res_ovf;
	logic [VAL_W-1:0]        res_d;

	assign accept = item.valid & item.ready;
	assign take   = result.valid & result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_READ;
			ST_READ: state_d = ST_ACC;
			ST_ACC:  state_d = ST_PREP;
			ST_PREP: state_d = (cnt_q == '0) ? ST_RES : ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_MEAN;
			ST_MEAN: state_d = ST_RES;
			ST_RES:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		div_start  = (state_q == ST_PREP) && (cnt_q != '0);
		out_load   = (state_q == ST_RES) && (!ovalid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// merge product, sign extended
	assign prod = val_q * $signed({1'b0, wt_q});

	// saturating accumulate and count update
	always_comb begin
		cur     = rvld_q ? rd_q : '0;
		add_raw = cur + addend_q;
		add_ovf = (cur[SUM_W-1] == addend_q[SUM_W-1]) && (add_raw[SUM_W-1] != cur[SUM_W-1]);
		add_sat = add_ovf ? (addend_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : add_raw;
		cnt_sum = {1'b0, cnt_q} + ((mode_q == MODE_ADD) ? (WT_W+1)'(1) : {1'b0, wt_q});
	end

	// magnitude of the sum for the divider
	assign mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// clamp the signed quotient to 32 bits
	always_comb begin
		if (neg_q) begin
			mean_big = (quot[SUM_W-1:VAL_W] != '0) ||
				(quot[VAL_W-1] && (quot[VAL_W-2:0] != '0));
			mean_d   = mean_big ? VAL_MIN : (~quot[VAL_W-1:0] + 1'b1);
		end else begin
			mean_big = (quot[SUM_W-1:VAL_W-1] != '0);
			mean_d   = mean_big ? VAL_MAX : quot[VAL_W-1:0];
		end
	end

	// residual, mean minus truth, saturated
	always_comb begin
		diff    = {mean_q[VAL_W-1], mean_q} - {val_q[VAL_W-1], val_q};
		res_ovf = (diff[VAL_W] != diff[VAL_W-1]);
		res_d   = res_ovf ? (diff[VAL_W] ? VAL_MIN : VAL_MAX) : diff[VAL_W-1:0];
	end

	lvrm_div #(
		.DVD_W (SUM_W),
		.DSR_W (WT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quot)
	);

	// control state: valid bits, count, flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			cnt_q    <= '0;
			sat_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (accept) begin
				sat_q <= 1'b0;
			end
			if (state_q == ST_ACC) begin
				case (mode_q)
					MODE_ADD, MODE_MERGE: begin
						if (ok_q) begin
							vld_q[idx_q] <= 1'b1;
							if (add_ovf) sat_q <= 1'b1;
						end
						if (eov_q) begin
							if (cnt_sum[WT_W]) begin
								cnt_q <= CNT_MAX;
								sat_q <= 1'b1;
							end else begin
								cnt_q <= cnt_sum[WT_W-1:0];
							end
						end
					end
					MODE_CLEAR: begin
						vld_q <= '0;
						cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if ((state_q == ST_MEAN) && mean_big) begin
				sat_q <= 1'b1;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (take) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// request capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(item.mode);
			idx_q  <= IW'(item.component);
			ok_q   <= (32'(item.component) < LEAF_DIM);
			val_q  <= item.value;
			wt_q   <= item.weight;
			eov_q  <= item.end_of_vector;
		end
		if (state_q == ST_READ) begin
			addend_q <= (mode_q == MODE_MERGE) ? SUM_W'(prod) :
				{{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q};
		end
		if (state_q == ST_ACC) begin
			case (mode_q)
				MODE_ADD, MODE_MERGE: sum_q <= ok_q ? add_sat : '0;
				MODE_QUERY:           sum_q <= ok_q ? cur : '0;
				default:              sum_q <= '0;
			endcase
		end
		if (state_q == ST_PREP) begin
			neg_q  <= sum_q[SUM_W-1];
			mean_q <= '0;
		end
		if (state_q == ST_MEAN) begin
			mean_q <= mean_d;
		end
		if (out_load) begin
			o_mean_q  <= mean_q;
			o_res_q   <= (mode_q == MODE_QUERY) ? res_d : '0;
			o_cnt_q   <= cnt_q;
			o_sat_q   <= sat_q | ((mode_q == MODE_QUERY) && res_ovf);
			o_empty_q <= (cnt_q == '0);
		end
	end

	// sum memory, one read and one write port
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q   <= sum_mem[idx_q];
			rvld_q <= ok_q && vld_q[idx_q];
		end
		if ((state_q == ST_ACC) && ok_q &&
			((mode_q == MODE_ADD) || (mode_q == MODE_MERGE))) begin
			sum_mem[idx_q] <= add_sat;
		end
	end

	assign result.valid        = ovalid_q;
	assign result.mean_value   = o_mean_q;
	assign result.residual     = o_res_q;
	assign result.sample_count = o_cnt_q;
	assign result.saturated    = o_sat_q;
	assign result.empty_res    = o_empty_q;

endmodule

>>> rtl/lvrm_div.sv
// radix-2 restoring divider, one quotient bit per cycle, unsigned operands
// depends on lvrm_pkg for default widths
module lvrm_div #(
	parameter int DVD_W = lvrm_pkg::SUM_W,
	parameter int DSR_W = lvrm_pkg::WT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	import lvrm_pkg::*;

	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

>>> rtl/lvrm_chk.sv
// port-level checker for leaf_vector_running_mean, with its bind
// depends on lvrm_pkg and leaf_vector_running_mean_macros.svh
`include "leaf_vector_running_mean_macros.svh"

module lvrm_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [lvrm_pkg::VAL_W-1:0] mean_value,
	input logic [lvrm_pkg::WT_W-1:0]       sample_count,
	input logic                            empty_res
);
	import lvrm_pkg::*;

	// one request in flight: busy right after an accept
	`LVRM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled result stays offered
	`LVRM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// empty flag follows the reported count
	`LVRM_ASSERT_IMP(a_empty_cnt, clk, arst_n, out_valid, empty_res == (sample_count == '0))

	// an empty leaf reports a zero mean
	`LVRM_ASSERT_IMP(a_empty_mean, clk, arst_n, out_valid && empty_res, mean_value == '0)

endmodule

bind leaf_vector_running_mean lvrm_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.mean_value   (result.mean_value),
	.sample_count (result.sample_count),
	.empty_res    (result.empty_res)
);
